/* src/mlpbp_pkg.sv */
// Shared types, constants and saturation helpers for the MLP online trainer.
// No dependencies; imported by mlpbp_div140 and mlp_online_backprop_trainer.
package mlpbp_pkg;

  // Network size and derived widths
  localparam int HIDDEN = 16;
  localparam int HID_AW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam logic [HID_AW-1:0] HID_LAST = HID_AW'(HIDDEN - 1);

  // Parameter slot map
  localparam logic [5:0] IDX_HB_BASE = 6'(HIDDEN);
  localparam logic [5:0] IDX_W2_BASE = 6'(2 * HIDDEN);
  localparam logic [5:0] IDX_OB      = 6'(3 * HIDDEN);
  localparam logic [5:0] IDX_IB      = 6'(3 * HIDDEN + 1);

  // Stream widths
  localparam int IN_DW  = 104;
  localparam int OUT_DW = 64;

  // Fixed-point constants
  localparam logic signed [31:0] NORM_OFF  = 32'sd2621440;  // 40.0 in Q16.16
  localparam logic signed [31:0] NORM_SPAN = 32'sd140;
  localparam logic signed [63:0] Q_ONE64   = 64'sd65536;
  localparam logic signed [63:0] SAT_HI    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO    = 64'shFFFF_FFFF_8000_0000;
  localparam logic [15:0]        LR_RESET  = 16'd655;

  // Divide by 140 as a quarter divided by 35: ceil(2^36/35), exact below 2^30
  localparam int          DIV_SHIFT = 36;
  localparam logic [30:0] DIV_MAGIC = 31'd1963413622;

  // One row of the parameter memory, one row per hidden neuron
  typedef struct packed {
    logic signed [31:0] w2;
    logic signed [31:0] hb;
    logic signed [31:0] w1;
  } param_row_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    begin
      if (v > SAT_HI) begin
        r = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
        r = 32'sh8000_0000;
      end else begin
        r = 32'(v);
      end
      return r;
    end
  endfunction

endpackage

/* src/mlpbp_div140.sv */
// Signed divide by 140, truncating toward zero, by reciprocal multiplication.
// Depends on mlpbp_pkg for the reciprocal constant and shift.
module mlpbp_div140 import mlpbp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] dividend,
  output logic               busy,
  output logic signed [31:0] quot
);

  logic        busy_r;
  logic        neg_r;
  logic [29:0] quart_r;
  logic [60:0] prod_r;
  logic [31:0] mag;
  logic [31:0] q_mag;

  // Magnitude of the dividend; it always fits in 32 bits
  assign mag = dividend[32] ? 32'(-dividend) : 32'(dividend);

  // Control: busy for the one multiply cycle after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  // Datapath: n/140 = floor(floor(n/4)/35), the latter by reciprocal
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r   <= dividend[32];
      quart_r <= mag[31:2];
    end
    if (busy_r) begin
      prod_r <= quart_r * DIV_MAGIC;
    end
  end

  assign q_mag = 32'(prod_r[60:DIV_SHIFT]);
  assign busy  = busy_r;
  assign quot  = neg_r ? -signed'(q_mag) : signed'(q_mag);

endmodule

/* src/mlp_online_backprop_trainer.sv */
// Top level of the online MLP trainer: sequencer, shared multiplier, memories.
// Depends on mlpbp_pkg and mlpbp_div140.
//
//  channel | ports                        | carries
//  --------+------------------------------+-------------------------------------------
//  in      | in_tvalid/in_tready/in_tdata | mode in tuser; index, value, sample, target
//  out     | out_tvalid/out_tready        | prediction, absolute error
//  cfg     | cfg_we/cfg_wdata             | learning rate, Q0.16
//
// A bias load is stored on accept, a weight or hidden-bias load by row read-modify-write.
// A training beat waits in S_NORM on the reciprocal divide-by-140 normalisers, then
// runs each neuron forward (S_F_MUL, S_F_PRE, S_F_ACC), output, error and step, and
// each neuron backward (S_B_MUL, S_B_HERR, S_B_CLIP, S_B_WB), all through the one
// 32x32 multiplier; in_tready stays low until the beat is done.
// Reset clears the stores at once through per-row valid flags; no sweep.
// A waiting result holds the block only when the next result is ready to go out.
module mlp_online_backprop_trainer import mlpbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [5:0] param_index, [37:6] param_value, [69:38] sample_in,
  // [101:70] target, [103:102] zero
  input  logic [IN_DW-1:0]  in_tdata,
  // [0] mode
  input  logic [0:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [31:0] prediction, [62:32] abs_error, [63] zero
  output logic [OUT_DW-1:0] out_tdata,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_LD_WR  = 14'b00000000000010,
    S_NORM   = 14'b00000000000100,
    S_F_MUL  = 14'b00000000001000,
    S_F_PRE  = 14'b00000000010000,
    S_F_ACC  = 14'b00000000100000,
    S_Y_SUM  = 14'b00000001000000,
    S_P_MUL  = 14'b00000010000000,
    S_P_LR   = 14'b00000100000000,
    S_P_OUT  = 14'b00001000000000,
    S_B_MUL  = 14'b00010000000000,
    S_B_HERR = 14'b00100000000000,
    S_B_CLIP = 14'b01000000000000,
    S_B_WB   = 14'b10000000000000
  } state_t;

  typedef enum logic [1:0] {
    FLD_W1 = 2'd0,
    FLD_HB = 2'd1,
    FLD_W2 = 2'd2
  } fld_t;

  localparam int ACC_W = 56;

  state_t state_r, state_nxt;

  // Control and state registers
  logic [15:0]        lr_r;
  logic signed [31:0] ob_r;
  logic signed [31:0] ib_r;
  logic [HIDDEN-1:0]  vld_r;
  logic               out_valid_r;

  // Working registers
  logic [HID_AW-1:0]  ld_row_r;
  fld_t               ld_fld_r;
  logic signed [31:0] ld_val_r;
  logic signed [31:0] tgt_r;
  logic [HID_AW-1:0]  idx_r;
  logic signed [31:0] e_r, nt_r, y_r, err_r, pred_r, step_r, herr_r, wn_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [63:0] prod_r;
  logic [OUT_DW-1:0]  out_data_r;

  // Memories
  param_row_t         pmem [HIDDEN];
  param_row_t         prow_q_r;
  logic               pvld_q_r;
  logic signed [31:0] smem [HIDDEN];
  logic signed [31:0] pre_q_r;

  // Sequencer outputs
  logic               p_ren, p_wen, s_wen;
  logic [HID_AW-1:0]  p_raddr, p_waddr;
  param_row_t         p_wdata;
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic               out_go, div_go;

  // Input decode
  logic               in_acc;
  logic [5:0]         in_idx;
  logic               in_is_row;
  logic [HID_AW-1:0]  in_row;
  fld_t               in_fld;

  // Datapath helpers
  param_row_t         row_m;
  logic signed [31:0] lr_s, prod_q, pre_c, h_c, hq, hb_new;
  logic signed [63:0] wsum, diff_c, mag_c;
  logic signed [31:0] wclip;
  logic [30:0]        abs_c;

  // Normalisers
  logic               busy_x, busy_t;
  logic signed [31:0] norm_x, norm_t;

  mlpbp_div140 u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (33'(signed'(in_tdata[69:38])) + 33'(NORM_OFF)),
    .busy     (busy_x),
    .quot     (norm_x)
  );

  mlpbp_div140 u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (33'(signed'(in_tdata[101:70])) + 33'(NORM_OFF)),
    .busy     (busy_t),
    .quot     (norm_t)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[5:0];

  // Slot decode into memory row and field
  always_comb begin
    in_is_row = 1'b1;
    in_fld    = FLD_W1;
    in_row    = '0;
    if (in_idx < IDX_HB_BASE) begin
      in_row = HID_AW'(in_idx);
    end else if (in_idx < IDX_W2_BASE) begin
      in_fld = FLD_HB;
      in_row = HID_AW'(in_idx - IDX_HB_BASE);
    end else if (in_idx < IDX_OB) begin
      in_fld = FLD_W2;
      in_row = HID_AW'(in_idx - IDX_W2_BASE);
    end else begin
      in_is_row = 1'b0;
    end
  end

  // Rows never written read as zero
  assign row_m  = pvld_q_r ? prow_q_r : '0;
  assign lr_s   = signed'({16'b0, lr_r});
  assign prod_q = sat32(prod_r >>> 16);
  assign pre_c  = sat32(64'(prod_q) + 64'(row_m.hb));
  assign h_c    = (pre_c > 32'sd0) ? pre_c : 32'sd0;
  assign hq     = (pre_q_r > 32'sd0) ? pre_q_r : 32'sd0;
  assign hb_new = sat32(64'(row_m.hb) + 64'(prod_q));

  // Output weight update, clipped to +-1.0
  assign wsum = 64'(row_m.w2) + 64'(prod_q);
  always_comb begin
    if (wsum > Q_ONE64) begin
      wclip = 32'(Q_ONE64);
    end else if (wsum < -Q_ONE64) begin
      wclip = 32'(-Q_ONE64);
    end else begin
      wclip = 32'(wsum);
    end
  end

  // Absolute error, saturated to 31 bits
  assign diff_c = 64'(tgt_r) - 64'(pred_r);
  assign mag_c  = (diff_c < 64'sd0) ? -diff_c : diff_c;
  assign abs_c  = (mag_c > SAT_HI) ? 31'h7FFF_FFFF : 31'(mag_c);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    p_ren     = 1'b0;
    p_raddr   = idx_r;
    p_wen     = 1'b0;
    p_waddr   = idx_r;
    p_wdata   = row_m;
    s_wen     = 1'b0;
    mul_en    = 1'b0;
    mul_a     = e_r;
    mul_b     = row_m.w1;
    out_go    = 1'b0;
    div_go    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0]) begin
            div_go    = 1'b1;
            state_nxt = S_NORM;
          end else if (in_is_row) begin
            p_ren     = 1'b1;
            p_raddr   = in_row;
            state_nxt = S_LD_WR;
          end
        end
      end
      S_LD_WR: begin
        p_wen   = 1'b1;
        p_waddr = ld_row_r;
        case (ld_fld_r)
          FLD_W1:  p_wdata.w1 = ld_val_r;
          FLD_HB:  p_wdata.hb = ld_val_r;
          FLD_W2:  p_wdata.w2 = ld_val_r;
          default: p_wdata    = row_m;
        endcase
        state_nxt = S_IDLE;
      end
      S_NORM: begin
        if (!busy_x && !busy_t) begin
          p_ren     = 1'b1;
          p_raddr   = '0;
          state_nxt = S_F_MUL;
        end
      end
      S_F_MUL: begin
        mul_en    = 1'b1;
        state_nxt = S_F_PRE;
      end
      S_F_PRE: begin
        s_wen     = 1'b1;
        mul_en    = 1'b1;
        mul_a     = h_c;
        mul_b     = row_m.w2;
        state_nxt = S_F_ACC;
      end
      S_F_ACC: begin
        if (idx_r == HID_LAST) begin
          state_nxt = S_Y_SUM;
        end else begin
          p_ren     = 1'b1;
          p_raddr   = HID_AW'(idx_r + 1'b1);
          state_nxt = S_F_MUL;
        end
      end
      S_Y_SUM: begin
        state_nxt = S_P_MUL;
      end
      S_P_MUL: begin
        mul_en    = 1'b1;
        mul_a     = y_r;
        mul_b     = NORM_SPAN;
        state_nxt = S_P_LR;
      end
      S_P_LR: begin
        mul_en    = 1'b1;
        mul_a     = lr_s;
        mul_b     = err_r;
        state_nxt = S_P_OUT;
      end
      S_P_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_go    = 1'b1;
          p_ren     = 1'b1;
          p_raddr   = '0;
          state_nxt = S_B_MUL;
        end
      end
      S_B_MUL: begin
        mul_en    = 1'b1;
        mul_a     = row_m.w2;
        mul_b     = err_r;
        state_nxt = S_B_HERR;
      end
      S_B_HERR: begin
        mul_en    = 1'b1;
        mul_a     = step_r;
        mul_b     = hq;
        state_nxt = S_B_CLIP;
      end
      S_B_CLIP: begin
        mul_en    = 1'b1;
        mul_a     = lr_s;
        mul_b     = herr_r;
        state_nxt = S_B_WB;
      end
      S_B_WB: begin
        p_wen      = 1'b1;
        p_wdata.w2 = wn_r;
        p_wdata.hb = hb_new;
        if (idx_r == HID_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          p_ren     = 1'b1;
          p_raddr   = HID_AW'(idx_r + 1'b1);
          state_nxt = S_B_MUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lr_r        <= LR_RESET;
      ob_r        <= '0;
      ib_r        <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        lr_r <= cfg_wdata;
      end
      if (in_acc && !in_tuser[0]) begin
        if (in_idx == IDX_OB) begin
          ob_r <= signed'(in_tdata[37:6]);
        end else if (in_idx == IDX_IB) begin
          ib_r <= signed'(in_tdata[37:6]);
        end
      end
      if (out_go) begin
        ob_r <= sat32(64'(ob_r) + 64'(prod_q));
      end
      if (p_wen) begin
        vld_r[p_waddr] <= 1'b1;
      end
      if (out_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and shared multiplier
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == S_IDLE && in_acc) begin
      ld_row_r <= in_row;
      ld_fld_r <= in_fld;
      ld_val_r <= signed'(in_tdata[37:6]);
      tgt_r    <= signed'(in_tdata[101:70]);
    end
    if (state_r == S_NORM) begin
      e_r   <= (sat32(64'(norm_x) + 64'(ib_r)) > 32'sd0) ?
               sat32(64'(norm_x) + 64'(ib_r)) : 32'sd0;
      nt_r  <= norm_t;
      acc_r <= '0;
      idx_r <= '0;
    end
    if (state_r == S_F_ACC) begin
      acc_r <= acc_r + ACC_W'(prod_r >>> 16);
      idx_r <= HID_AW'(idx_r + 1'b1);
    end
    if (state_r == S_Y_SUM) begin
      y_r <= sat32(64'(acc_r) + 64'(ob_r));
    end
    if (state_r == S_P_MUL) begin
      err_r <= sat32(64'(nt_r) - 64'(y_r));
    end
    if (state_r == S_P_LR) begin
      pred_r <= sat32(prod_r - 64'(NORM_OFF));
    end
    if (out_go) begin
      out_data_r <= {1'b0, abs_c, pred_r};
      step_r     <= prod_q;
      idx_r      <= '0;
    end
    if (state_r == S_B_HERR) begin
      herr_r <= (pre_q_r > 32'sd0) ? prod_q : 32'sd0;
    end
    if (state_r == S_B_CLIP) begin
      wn_r <= wclip;
    end
    if (state_r == S_B_WB) begin
      idx_r <= HID_AW'(idx_r + 1'b1);
    end
  end

  // Parameter memory and pre-activation scratch
  always_ff @(posedge clk) begin
    if (p_wen) begin
      pmem[p_waddr] <= p_wdata;
    end
    if (s_wen) begin
      smem[idx_r] <= pre_c;
    end
    if (p_ren) begin
      prow_q_r <= pmem[p_raddr];
      pvld_q_r <= vld_r[p_raddr];
      pre_q_r  <= smem[p_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Both normalisers start on a training beat
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_go |=> (busy_x && busy_t))
    else $error("normalisers did not start on a training beat");

  // The two normalisers run in lockstep
  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    busy_x == busy_t)
    else $error("normalisers out of step");

  // The parameter memory is written only by a load or by the write-back step
  a_wr_src: assert property (@(posedge clk) disable iff (!rst_n)
    p_wen |-> (state_r == S_LD_WR || state_r == S_B_WB))
    else $error("parameter memory written outside load or write-back");

  // A result appears only after the prediction step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_P_OUT))
    else $error("result raised outside the output step");

endmodule
